FILE: hw/rtl/pwq_pkg.sv
package pwq_pkg;

	localparam int QUEUE_DEPTH   = 16;
	localparam int PRIORITY_BITS = 5;
	localparam int TASK_ID_BITS  = 4;

	localparam int OP_W   = 2;
	localparam int ST_W   = 2;
	localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
	localparam logic [OP_W-1:0] OP_POP    = 2'd2;

	localparam logic [ST_W-1:0] ST_OK        = 2'd0;
	localparam logic [ST_W-1:0] ST_FULL      = 2'd1;
	localparam logic [ST_W-1:0] ST_EMPTY     = 2'd2;
	localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd3;

	localparam int IN_OP_LO   = 0;
	localparam int IN_TASK_LO = IN_OP_LO + OP_W;
	localparam int IN_PRIO_LO = IN_TASK_LO + TASK_ID_BITS;
	localparam int IN_RAW_W   = IN_PRIO_LO + PRIORITY_BITS;
	localparam int IN_TDATA_W = ((IN_RAW_W + 7) / 8) * 8;

	localparam int OUT_ST_LO    = 0;
	localparam int OUT_POP_LO   = OUT_ST_LO + ST_W;
	localparam int OUT_CNT_LO   = OUT_POP_LO + TASK_ID_BITS;
	localparam int OUT_HEAD_LO  = OUT_CNT_LO + CNT_W;
	localparam int OUT_HV_BIT   = OUT_HEAD_LO + TASK_ID_BITS;
	localparam int OUT_RAW_W    = OUT_HV_BIT + 1;
	localparam int OUT_TDATA_W  = ((OUT_RAW_W + 7) / 8) * 8;

	typedef struct packed {
		logic [TASK_ID_BITS-1:0]  task_id;
		logic [PRIORITY_BITS-1:0] prio;
	} slot_t;

	typedef struct packed {
		logic                     ins;
		logic                     rem;
		logic [TASK_ID_BITS-1:0]  task_id;
		logic [PRIORITY_BITS-1:0] prio;
	} cmd_t;

endpackage

FILE: hw/rtl/pwq_cell.sv
module pwq_cell import pwq_pkg::*; (
	input  logic  clk,
	input  cmd_t  cmd,
	input  logic  valid,
	input  logic  left_stay,
	input  slot_t left_slot,
	input  slot_t right_slot,
	input  logic  hit_in,
	output logic  stay,
	output logic  hit_out,
	output slot_t slot,
	output slot_t slot_next
);

	slot_t slot_q;
	slot_t new_slot;

	assign new_slot.task_id = cmd.task_id;
	assign new_slot.prio    = cmd.prio;

	// A task stays put on insert when it is at least as urgent as the new one.
	assign stay    = valid && (slot_q.prio >= cmd.prio);
	assign hit_out = hit_in || (cmd.rem && valid && (slot_q.task_id == cmd.task_id));
	assign slot    = slot_q;

	always_comb begin
		priority if (cmd.ins && !stay) begin
			slot_next = left_stay ? new_slot : left_slot;
		end else if (hit_out) begin
			slot_next = right_slot;
		end else begin
			slot_next = slot_q;
		end
	end

	always_ff @(posedge clk) begin
		slot_q <= slot_next;
	end

endmodule

FILE: hw/rtl/priority_wait_queue.sv
// Priority wait queue of up to QUEUE_DEPTH tasks, held in a row of cells with the head in the
// first cell. Each item is an insert, a remove by task id, a pop or a no-op, and it yields
// exactly one result item with the status, the popped task, the new count and the new head.
// An item is taken in every cycle while the output register is free or being emptied, and its
// result appears in the cycle after acceptance. All cells compare against the item at once;
// the remove search ripples one bit through the row, which sets the cycle time for deep queues.
module priority_wait_queue import pwq_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// Fields from bit 0: op, task_id, priority_req, zero fill.
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// Fields from bit 0: status, popped_task, queue_count, head_task, head_valid, zero fill to a byte (none here).
	output logic [OUT_TDATA_W-1:0] m_tdata
);

	logic [OP_W-1:0]          in_op;
	logic [TASK_ID_BITS-1:0]  in_task;
	logic [PRIORITY_BITS-1:0] in_prio;
	logic                     accept;
	logic                     full;
	logic                     empty;
	logic                     found;
	cmd_t                     cmd;

	logic [CNT_W-1:0]         count_q;
	logic [CNT_W-1:0]         count_next;
	logic [ST_W-1:0]          status;
	logic [TASK_ID_BITS-1:0]  popped;

	logic                     m_tvalid_q;
	logic [OUT_RAW_W-1:0]     out_q;

	logic  [QUEUE_DEPTH-1:0]  stay;
	logic  [QUEUE_DEPTH-1:0]  hit;
	slot_t                    slot [QUEUE_DEPTH];
	slot_t                    slot_next [QUEUE_DEPTH];

	assign in_op   = s_tdata[IN_TASK_LO-1:IN_OP_LO];
	assign in_task = s_tdata[IN_PRIO_LO-1:IN_TASK_LO];
	assign in_prio = s_tdata[IN_RAW_W-1:IN_PRIO_LO];

	assign s_tready = !m_tvalid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	assign full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty = (count_q == '0);

	assign cmd.ins     = accept && (in_op == OP_INSERT) && !full;
	assign cmd.rem     = accept && (in_op == OP_REMOVE);
	assign cmd.task_id = in_task;
	assign cmd.prio    = in_prio;

	genvar gi;
	generate
		for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
			logic  valid_c;
			logic  left_stay_c;
			logic  hit_in_c;
			slot_t left_c;
			slot_t right_c;

			assign valid_c = (CNT_W'(gi) < count_q);

			if (gi == 0) begin : g_first
				assign left_stay_c = 1'b1;
				assign left_c      = '0;
				assign hit_in_c    = accept && (in_op == OP_POP) && !empty;
			end else begin : g_rest
				assign left_stay_c = stay[gi-1];
				assign left_c      = slot[gi-1];
				assign hit_in_c    = hit[gi-1];
			end

			if (gi == QUEUE_DEPTH - 1) begin : g_last
				assign right_c = '0;
			end else begin : g_inner
				assign right_c = slot[gi+1];
			end

			pwq_cell u_cell (
				.clk        (clk),
				.cmd        (cmd),
				.valid      (valid_c),
				.left_stay  (left_stay_c),
				.left_slot  (left_c),
				.right_slot (right_c),
				.hit_in     (hit_in_c),
				.stay       (stay[gi]),
				.hit_out    (hit[gi]),
				.slot       (slot[gi]),
				.slot_next  (slot_next[gi])
			);
		end
	endgenerate

	assign found = hit[QUEUE_DEPTH-1];

	always_comb begin
		status     = ST_OK;
		popped     = '0;
		count_next = count_q;
		unique case (in_op)
			OP_INSERT: begin
				if (full) begin
					status = ST_FULL;
				end else begin
					count_next = count_q + CNT_W'(1);
				end
			end
			OP_REMOVE: begin
				if (found) begin
					count_next = count_q - CNT_W'(1);
				end else begin
					status = ST_NOT_FOUND;
				end
			end
			OP_POP: begin
				if (empty) begin
					status = ST_EMPTY;
				end else begin
					popped     = slot[0].task_id;
					count_next = count_q - CNT_W'(1);
				end
			end
			default: begin
				status = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q    <= count_next;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_q <= {(count_next != '0),
				(count_next != '0) ? slot_next[0].task_id : {TASK_ID_BITS{1'b0}},
				count_next, popped, status};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = OUT_TDATA_W'(out_q);

endmodule

FILE: hw/rtl/pwq_checker.sv
module pwq_checker import pwq_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata
);

	logic [ST_W-1:0]  st;
	logic [CNT_W-1:0] cnt;
	logic             hv;

	assign st  = m_tdata[OUT_POP_LO-1:OUT_ST_LO];
	assign cnt = m_tdata[OUT_HEAD_LO-1:OUT_CNT_LO];
	assign hv  = m_tdata[OUT_HV_BIT];

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("Result item changed while stalled.");

	a_head_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (hv == (cnt != '0)))
		else $error("Head valid disagrees with the count.");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (cnt <= CNT_W'(QUEUE_DEPTH)))
		else $error("Count exceeds the queue depth.");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (st == ST_FULL) |-> (cnt == CNT_W'(QUEUE_DEPTH)))
		else $error("Full status with a queue that is not full.");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (st == ST_EMPTY) |-> (cnt == '0) && !hv)
		else $error("Empty status with a queue that is not empty.");

endmodule

bind priority_wait_queue pwq_checker u_pwq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

FILE: verif/tb_priority_wait_queue.sv
`timescale 1ns / 1ps

module tb_priority_wait_queue;
	import pwq_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int TASK_MAX     = (1 << TASK_ID_BITS) - 1;
	localparam int PRIO_MAX     = (1 << PRIORITY_BITS) - 1;
	localparam int LIMIT_CYCLES = 400000;
	localparam int LONG_HOLD    = 300;
	localparam int DRAIN_CYCLES = 8;
	localparam int PHASES       = 12;
	localparam int PHASE_ITEMS  = 109;

	typedef struct packed {
		logic                    head_valid;
		logic [TASK_ID_BITS-1:0] head_task;
		logic [CNT_W-1:0]        queue_count;
		logic [TASK_ID_BITS-1:0] popped_task;
		logic [ST_W-1:0]         status;
	} result_t;

	class wait_queue_scoreboard;
		slot_t   waiting[$];
		result_t expected[$];
		int      error_count;

		function new();
			error_count = 0;
		endfunction

		function void note_item(logic [OP_W-1:0] op, logic [TASK_ID_BITS-1:0] id,
				logic [PRIORITY_BITS-1:0] prio);
			result_t r;
			slot_t   s;
			int      pos;
			r = '0;
			r.status = ST_OK;
			case (op)
				OP_INSERT: begin
					if (waiting.size() >= QUEUE_DEPTH) begin
						r.status = ST_FULL;
					end else begin
						pos = 0;
						while (pos < waiting.size() && waiting[pos].prio >= prio)
							pos++;
						s.task_id = id;
						s.prio    = prio;
						waiting.insert(pos, s);
					end
				end
				OP_REMOVE: begin
					pos = -1;
					for (int i = 0; i < waiting.size() && pos < 0; i++)
						if (waiting[i].task_id == id)
							pos = i;
					if (pos < 0) begin
						r.status = ST_NOT_FOUND;
					end else begin
						waiting.delete(pos);
					end
				end
				OP_POP: begin
					if (waiting.size() == 0) begin
						r.status = ST_EMPTY;
					end else begin
						r.popped_task = waiting[0].task_id;
						void'(waiting.pop_front());
					end
				end
				default: begin
				end
			endcase
			r.queue_count = CNT_W'(waiting.size());
			r.head_valid  = waiting.size() != 0;
			r.head_task   = r.head_valid ? waiting[0].task_id : '0;
			expected.push_back(r);
		endfunction

		function void flag_error(string what, result_t want, result_t got);
			string want_s;
			string got_s;
			error_count++;
			if (error_count <= 10) begin
				want_s = $sformatf("st=%0d pop=%0d cnt=%0d head=%0d hv=%0d",
					want.status, want.popped_task, want.queue_count,
					want.head_task, want.head_valid);
				got_s = $sformatf("st=%0d pop=%0d cnt=%0d head=%0d hv=%0d",
					got.status, got.popped_task, got.queue_count,
					got.head_task, got.head_valid);
				$display("%0t: %s: expected %s, got %s", $time, what, want_s, got_s);
			end
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (expected.size() == 0) begin
				flag_error("unexpected result", '0, got);
				return;
			end
			want = expected.pop_front();
			if (got.status !== want.status || got.popped_task !== want.popped_task ||
					got.queue_count !== want.queue_count || got.head_task !== want.head_task ||
					got.head_valid !== want.head_valid)
				flag_error("mismatch", want, got);
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;

	wait_queue_scoreboard sb;
	int hold_requests = 0;
	int cycles = 0;

	priority_wait_queue u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("tb_priority_wait_queue: errors");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid === 1'b1 && s_tready === 1'b1)
				sb.note_item(s_tdata[IN_OP_LO +: OP_W], s_tdata[IN_TASK_LO +: TASK_ID_BITS],
					s_tdata[IN_PRIO_LO +: PRIORITY_BITS]);
			if (m_tvalid === 1'b1 && m_tready === 1'b1)
				sb.check_result(result_t'(m_tdata[OUT_RAW_W-1:0]));
		end
	end

	initial begin
		int  holds_done;
		int  stretch_left;
		int  ready_pct;
		bit  want_hold;
		holds_done   = 0;
		stretch_left = 0;
		ready_pct    = 100;
		m_tready     = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			want_hold = hold_requests != holds_done;
			@(negedge clk);
			if (want_hold) begin
				holds_done++;
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
			end else begin
				if (stretch_left == 0) begin
					stretch_left = $urandom_range(10, 80);
					case ($urandom_range(0, 3))
						0: ready_pct = 100;
						1: ready_pct = 85;
						2: ready_pct = 60;
						default: ready_pct = 30;
					endcase
				end
				stretch_left--;
				m_tready <= $urandom_range(0, 99) < ready_pct;
			end
		end
	end

	task automatic send_item(input logic [OP_W-1:0] op, input logic [TASK_ID_BITS-1:0] id,
			input logic [PRIORITY_BITS-1:0] prio);
		logic [IN_TDATA_W-1:0] word;
		word = '0;
		word[IN_OP_LO +: OP_W]            = op;
		word[IN_TASK_LO +: TASK_ID_BITS]  = id;
		word[IN_PRIO_LO +: PRIORITY_BITS] = prio;
		s_tvalid <= 1'b1;
		s_tdata  <= word;
		@(posedge clk);
		while (s_tready !== 1'b1)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic idle_cycles(input int n);
		s_tvalid <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	task automatic send_random(input int insert_pct, input int prio_lo);
		logic [OP_W-1:0]          op;
		logic [TASK_ID_BITS-1:0]  id;
		logic [PRIORITY_BITS-1:0] prio;
		int                       pick;
		int                       depth;
		pick  = $urandom_range(0, 99);
		depth = sb.waiting.size();
		if (pick < insert_pct) begin
			op = OP_INSERT;
		end else if (pick >= 97) begin
			op = OP_UNUSED;
		end else if ((pick - insert_pct) % 2 == 0) begin
			op = OP_REMOVE;
		end else begin
			op = OP_POP;
		end
		id = TASK_ID_BITS'($urandom_range(0, TASK_MAX));
		if (op == OP_REMOVE && depth > 0 && $urandom_range(0, 3) != 0)
			id = sb.waiting[$urandom_range(0, depth - 1)].task_id;
		if ($urandom_range(0, 3) == 0) begin
			prio = PRIORITY_BITS'($urandom_range(0, PRIO_MAX));
		end else begin
			prio = PRIORITY_BITS'(prio_lo + int'($urandom_range(0, 3)));
		end
		send_item(op, id, prio);
	endtask

	initial begin
		int insert_pct;
		int prio_lo;
		int sent;
		int burst;
		bit no_gaps;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		arst_n   = 1'b0;
		sb = new();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_item(OP_POP, 4'd0, 5'd0);
		send_item(OP_REMOVE, 4'd5, 5'd0);
		send_item(OP_UNUSED, 4'd15, 5'd31);
		send_item(OP_INSERT, 4'd0, 5'd0);
		send_item(OP_INSERT, 4'd15, 5'd31);
		send_item(OP_INSERT, 4'd7, 5'd31);
		send_item(OP_INSERT, 4'd3, 5'd0);
		send_item(OP_INSERT, 4'd7, 5'd10);
		send_item(OP_UNUSED, 4'd0, 5'd0);
		send_item(OP_REMOVE, 4'd7, 5'd0);
		send_item(OP_REMOVE, 4'd9, 5'd0);
		send_item(OP_POP, 4'd0, 5'd0);
		send_item(OP_REMOVE, 4'd3, 5'd0);
		send_item(OP_INSERT, 4'd10, 5'd21);
		send_item(OP_INSERT, 4'd5, 5'd10);
		send_item(OP_INSERT, 4'd12, 5'd21);
		send_item(OP_REMOVE, 4'd0, 5'd0);
		repeat (5) send_item(OP_POP, 4'd0, 5'd0);
		idle_cycles(1);

		for (int ph = 0; ph < PHASES; ph++) begin
			insert_pct = (ph % 3 == 0) ? 85 : (ph % 3 == 1) ? 50 : 20;
			prio_lo    = $urandom_range(0, PRIO_MAX - 3);
			no_gaps    = ph % 4 == 1;
			if (ph % 4 == 2) begin
				hold_requests++;
				repeat (40) send_random(85, prio_lo);
			end
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				burst = $urandom_range(1, 24);
				for (int b = 0; b < burst && sent < PHASE_ITEMS; b++) begin
					send_random(insert_pct, prio_lo);
					sent++;
				end
				if (!no_gaps && $urandom_range(0, 2) != 0)
					idle_cycles($urandom_range(1, 6));
			end
			if (ph % 4 == 3) begin
				idle_cycles(1);
				while (sb.expected.size() != 0)
					@(negedge clk);
			end
		end

		idle_cycles(1);
		while (sb.expected.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (sb.error_count == 0 && sb.expected.size() == 0) begin
			$display("tb_priority_wait_queue: clean");
		end else begin
			$display("tb_priority_wait_queue: errors");
		end
		$finish;
	end

endmodule

FILE: sim.f
hw/rtl/pwq_pkg.sv
hw/rtl/pwq_cell.sv
hw/rtl/priority_wait_queue.sv
hw/rtl/pwq_checker.sv
verif/tb_priority_wait_queue.sv
